@@ hw/rtl/pressure_temp_compensation_unit_assert.svh @@
// Assertion macros used by the checker of the compensation unit.
// The enclosing scope must provide clk_i and rst_ni.
`ifndef PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/ptc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the compensation unit.
// Used by the top level, front, queue, divider and back end; depends on nothing.
`default_nettype none

package ptc_pkg;

  // Divider width and pipeline geometry.
  localparam int unsigned DivBits   = 32;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAw       = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  // Back end: operand stage, two dividers, eight middle stages, four tail stages.
  localparam int unsigned BackDepth = 2 * DivBits + 13;

  // Configuration port.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_e;

  // Algorithm constants.
  localparam logic [31:0] KB5Round = 32'd8;
  localparam logic [31:0] KB6Ofs   = 32'd4000;
  localparam logic [31:0] KAc4Ofs  = 32'd32768;
  localparam logic [31:0] KRound2  = 32'd2;
  localparam logic [31:0] KP3038   = 32'd3038;
  localparam logic [31:0] KPm7357  = 32'hFFFF_E343;
  localparam logic [31:0] KP3791   = 32'd3791;

  // Calibration registers as written.
  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cal_t;

  // Queue entry between front and back.
  typedef struct packed {
    logic [31:0] prod;
    logic [15:0] up;
  } qent_t;

  // Values riding alongside the first divider.
  typedef struct packed {
    logic [31:0] x1;
    logic [15:0] up;
    logic        negq;
    logic        fault;
  } sb1_t;

  // Values riding alongside the second divider.
  typedef struct packed {
    logic [15:0] tsat;
    logic        dbl;
    logic        fault;
  } sb2_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Signed division by 2^k truncating toward zero.
  function automatic logic [31:0] sdivp(logic [31:0] n, logic [4:0] k);
    logic [31:0] bias;
    bias = n[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return $signed(n + bias) >>> k;
  endfunction

  // Saturate a 32-bit signed value to 16 bits.
  function automatic logic [15:0] sat16(logic [31:0] t);
    logic [15:0] r;
    if (t[31] && (t < 32'hFFFF_8000)) begin
      r = 16'h8000;
    end else if (!t[31] && (t > 32'h0000_7FFF)) begin
      r = 16'h7FFF;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pressure_temp_compensation_unit.sv @@
// Top level of the barometric pressure and temperature compensation unit.
// Depends on ptc_pkg, ptc_front, ptc_fifo and ptc_back.
//
// Usage:
// - Write the five calibration words through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no beat is in flight; indexes beyond the list are ignored.
// - Each input beat carries one raw temperature and one raw pressure word.
//   Each one yields exactly one output beat with the temperature in 0.1 C,
//   the pressure in pascals and a divide fault flag on tuser.
// - Throughput is one beat per cycle while the receiver is ready. Each beat
//   passes the front holding stage, the queue and the 77 stage back end,
//   which is dominated by two 32 stage pipelined dividers (one quotient
//   bit per stage).
// - When the receiver stalls, the back end holds as a whole; the front end
//   keeps taking beats until its 4 entry queue and holding stage are full.
// - Reset clears all calibration words to zero and empties the pipeline;
//   with zero calibration every result reports a divide fault.
`default_nettype none

module pressure_temp_compensation_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ptc_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] raw_temperature, [31:16] raw_pressure
  input  wire logic [31:0]                 s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [15:0] temperature_tenths, [47:16] pressure_pa
  output logic [47:0]                      m_axis_tdata,
  // [0] divide_fault
  output logic                             m_axis_tuser
);

  ptc_pkg::cal_t  cal_q;
  logic           q_push, q_pop, q_full, q_empty;
  ptc_pkg::qent_t q_in, q_out;

  // Calibration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      case (ptc_pkg::cfg_idx_e'(cfg_idx_i))
        ptc_pkg::CFG_AC1_AC2: cal_q.ac1_ac2 <= cfg_wdata_i;
        ptc_pkg::CFG_AC3_AC4: cal_q.ac3_ac4 <= cfg_wdata_i;
        ptc_pkg::CFG_AC5_AC6: cal_q.ac5_ac6 <= cfg_wdata_i;
        ptc_pkg::CFG_B1_B2:   cal_q.b1_b2   <= cfg_wdata_i;
        ptc_pkg::CFG_MC_MD:   cal_q.mc_md   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cal_i      (cal_q),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  ptc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ptc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cal_i      (cal_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ptc_front.sv @@
// Front end: takes input beats, splits the fields and forms the first
// temperature product. Depends on ptc_pkg.
`default_nettype none

module ptc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ptc_pkg::cal_t cal_i,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [31:0]   s_tdata_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output ptc_pkg::qent_t     q_data_o
);

  logic           vld_q;
  ptc_pkg::qent_t ent_q, ent_d;
  logic [31:0]    diff;

  // (UT - AC6) * AC5, kept to 32 bits.
  assign diff       = {16'h0, s_tdata_i[15:0]} - {16'h0, cal_i.ac5_ac6[15:0]};
  assign ent_d.prod = diff * {16'h0, cal_i.ac5_ac6[31:16]};
  assign ent_d.up   = s_tdata_i[31:16];

  // One holding stage; it drains into the queue whenever there is room.
  assign q_push_o   = vld_q && !q_full_i;
  assign s_tready_o = !vld_q || !q_full_i;
  assign q_data_o   = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_tready_o) begin
      vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptc_fifo.sv @@
// Short queue between the front and back ends of the compensation unit.
// Depends on ptc_pkg for the entry type and depth.
`default_nettype none

module ptc_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ptc_pkg::qent_t data_i,
  input  wire logic           pop_i,
  output ptc_pkg::qent_t      data_o,
  output logic                full_o,
  output logic                empty_o
);

  ptc_pkg::qent_t                 mem_q [ptc_pkg::QDepth];
  logic [ptc_pkg::QAw-1:0]        wp_q, rp_q;
  logic [ptc_pkg::QCntW-1:0]      cnt_q;

  assign full_o  = cnt_q == ptc_pkg::QCntW'(ptc_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == ptc_pkg::QAw'(ptc_pkg::QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == ptc_pkg::QAw'(ptc_pkg::QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptc_udiv.sv @@
// Pipelined unsigned divider, one quotient bit per stage, stalled by en_i.
// Depends on ptc_pkg for the operand width.
`default_nettype none

module ptc_udiv (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [ptc_pkg::DivBits-1:0] num_i,
  input  wire logic [ptc_pkg::DivBits-1:0] den_i,
  output logic [ptc_pkg::DivBits-1:0]      quo_o
);

  localparam int unsigned W = ptc_pkg::DivBits;

  logic [W-1:0] rem_q [W-1];
  logic [W-1:0] num_q [W-1];
  logic [W-1:0] den_q [W-1];
  logic [W-1:0] quo_q [W];

  assign quo_o = quo_q[W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] rem_in, num_in, den_in, quo_in;
    logic [W:0]   trial, diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Restoring step: shift in the next numerator bit and try a subtract.
    assign trial = {rem_in, num_in[W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = !diff[W];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_in[W-2:0], ge};
      end
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[W-1:0] : trial[W-1:0];
          num_q[k] <= {num_in[W-2:0], 1'b0};
          den_q[k] <= den_in;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptc_back.sv @@
// Back end: the compensation datapath with two pipelined dividers and the
// output register. Depends on ptc_pkg and ptc_udiv.
`default_nettype none

module ptc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ptc_pkg::cal_t  cal_i,
  input  wire logic           q_empty_i,
  input  wire ptc_pkg::qent_t q_data_i,
  output logic                q_pop_o,
  output logic                m_tvalid_o,
  input  wire logic           m_tready_i,
  output logic [47:0]         m_tdata_o,
  output logic                m_tuser_o
);

  localparam int unsigned W = ptc_pkg::DivBits;
  localparam int unsigned N = ptc_pkg::BackDepth;

  logic        en;
  logic        vld_q [N];

  // Coefficients.
  logic [31:0] ac1, ac2, ac3, ac4, b1, b2, mc, md;
  assign ac1 = ptc_pkg::sx16(cal_i.ac1_ac2[31:16]);
  assign ac2 = ptc_pkg::sx16(cal_i.ac1_ac2[15:0]);
  assign ac3 = ptc_pkg::sx16(cal_i.ac3_ac4[31:16]);
  assign ac4 = {16'h0, cal_i.ac3_ac4[15:0]};
  assign b1  = ptc_pkg::sx16(cal_i.b1_b2[31:16]);
  assign b2  = ptc_pkg::sx16(cal_i.b1_b2[15:0]);
  assign mc  = ptc_pkg::sx16(cal_i.mc_md[31:16]);
  assign md  = ptc_pkg::sx16(cal_i.mc_md[15:0]);

  // The whole pipe advances unless a finished result is held.
  assign en         = !vld_q[N-1] || m_tready_i;
  assign q_pop_o    = en && !q_empty_i;
  assign m_tvalid_o = vld_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= !q_empty_i;
      for (int i = 1; i < N; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Operand stage of the first divide: X2 = MC*2048 / (X1 + MD).
  logic [31:0] a_x1, a_den, a_num;
  logic [31:0] a_un_q, a_ud_q;
  ptc_pkg::sb1_t a_sb;
  assign a_x1  = ptc_pkg::sdivp(q_data_i.prod, 5'd15);
  assign a_den = a_x1 + md;
  assign a_num = mc << 11;

  ptc_pkg::sb1_t sb1_q [W];
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_un_q     <= a_num[31] ? 32'd0 - a_num : a_num;
      a_ud_q     <= a_den[31] ? 32'd0 - a_den : a_den;
      a_sb.x1    <= a_x1;
      a_sb.up    <= q_data_i.up;
      a_sb.negq  <= a_num[31] ^ a_den[31];
      a_sb.fault <= a_den == 32'd0;
      sb1_q[0]   <= a_sb;
      for (int i = 1; i < W; i++) begin
        sb1_q[i] <= sb1_q[i-1];
      end
    end
  end

  logic [31:0] d1_quo;
  ptc_udiv u_div1 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (a_un_q),
    .den_i (a_ud_q),
    .quo_o (d1_quo)
  );

  // Middle stages: B5, T, B6, B3, B4 and B7.
  logic [31:0] t1_b5_q, t2_b6_q, t3_sqp_q, t3_m2_q, t3_m3_q;
  logic [31:0] t4_sq_q, t4_x2a_q, t4_x1b_q, t5_mb2_q, t5_mb1_q, t5_x2a_q, t5_x1b_q;
  logic [31:0] t6_b3_q, t6_x3b_q, t7_m4_q, t7_b3_q;
  logic [15:0] tsat_q [2:7];
  logic [15:0] up_q   [1:7];
  logic        flt_q  [1:7];
  logic [31:0] t1_x2, t6_x3, t8_b7, t8_b4;

  assign t1_x2 = sb1_q[W-1].negq ? 32'd0 - d1_quo : d1_quo;
  assign t6_x3 = ptc_pkg::sdivp(t5_mb2_q, 5'd11) + t5_x2a_q;
  assign t8_b4 = {15'h0, t7_m4_q[31:15]};
  assign t8_b7 = {16'h0, up_q[7]} - t7_b3_q;

  ptc_pkg::sb2_t t8_sb;
  logic [31:0]   t8_num_q, t8_b4_q;
  ptc_pkg::sb2_t sb2_q [W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_b5_q   <= sb1_q[W-1].x1 + t1_x2;
      up_q[1]   <= sb1_q[W-1].up;
      flt_q[1]  <= sb1_q[W-1].fault;

      t2_b6_q   <= t1_b5_q - ptc_pkg::KB6Ofs;
      tsat_q[2] <= ptc_pkg::sat16(ptc_pkg::sdivp(t1_b5_q + ptc_pkg::KB5Round, 5'd4));

      t3_sqp_q  <= t2_b6_q * t2_b6_q;
      t3_m2_q   <= ac2 * t2_b6_q;
      t3_m3_q   <= ac3 * t2_b6_q;

      t4_sq_q   <= ptc_pkg::sdivp(t3_sqp_q, 5'd12);
      t4_x2a_q  <= ptc_pkg::sdivp(t3_m2_q, 5'd11);
      t4_x1b_q  <= ptc_pkg::sdivp(t3_m3_q, 5'd13);

      t5_mb2_q  <= b2 * t4_sq_q;
      t5_mb1_q  <= b1 * t4_sq_q;
      t5_x2a_q  <= t4_x2a_q;
      t5_x1b_q  <= t4_x1b_q;

      t6_b3_q   <= ptc_pkg::sdivp((ac1 << 2) + t6_x3 + ptc_pkg::KRound2, 5'd2);
      t6_x3b_q  <= ptc_pkg::sdivp(t5_x1b_q + ptc_pkg::sdivp(t5_mb1_q, 5'd16)
                                  + ptc_pkg::KRound2, 5'd2);

      t7_m4_q   <= ac4 * (t6_x3b_q + ptc_pkg::KAc4Ofs);
      t7_b3_q   <= t6_b3_q;

      for (int i = 2; i <= 7; i++) begin
        up_q[i]  <= up_q[i-1];
        flt_q[i] <= flt_q[i-1];
      end
      for (int i = 3; i <= 7; i++) begin
        tsat_q[i] <= tsat_q[i-1];
      end

      // Unsigned B7 / B4 with the doubling placed where it cannot overflow.
      t8_num_q    <= t8_b7[31] ? t8_b7 : t8_b7 << 1;
      t8_b4_q     <= t8_b4;
      t8_sb.tsat  <= tsat_q[7];
      t8_sb.dbl   <= t8_b7[31];
      t8_sb.fault <= flt_q[7] || (t8_b4 == 32'd0);

      sb2_q[0] <= t8_sb;
      for (int i = 1; i < W; i++) begin
        sb2_q[i] <= sb2_q[i-1];
      end
    end
  end

  logic [31:0] d2_quo;
  ptc_udiv u_div2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (t8_num_q),
    .den_i (t8_b4_q),
    .quo_o (d2_quo)
  );

  // Tail stages: the final pressure correction and the output register.
  logic [31:0]   u1_p_q, u1_x1_q, u2_p_q, u2_mp_q, u2_m7_q, u3_p_q, u3_m38_q, u3_x2_q;
  ptc_pkg::sb2_t u_sb_q [1:3];
  logic [31:0]   u1_p, u4_p;
  logic [47:0]   out_q;
  logic          flt_out_q;

  assign u1_p = sb2_q[W-1].dbl ? d2_quo << 1 : d2_quo;
  assign u4_p = u3_p_q + ptc_pkg::sdivp(ptc_pkg::sdivp(u3_m38_q, 5'd16) + u3_x2_q
                                        + ptc_pkg::KP3791, 5'd4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_p_q    <= u1_p;
      u1_x1_q   <= ptc_pkg::sdivp(u1_p, 5'd8);
      u_sb_q[1] <= sb2_q[W-1];

      u2_p_q    <= u1_p_q;
      u2_mp_q   <= u1_x1_q * u1_x1_q;
      u2_m7_q   <= ptc_pkg::KPm7357 * u1_p_q;
      u_sb_q[2] <= u_sb_q[1];

      u3_p_q    <= u2_p_q;
      u3_m38_q  <= u2_mp_q * ptc_pkg::KP3038;
      u3_x2_q   <= ptc_pkg::sdivp(u2_m7_q, 5'd16);
      u_sb_q[3] <= u_sb_q[2];

      out_q     <= u_sb_q[3].fault ? 48'h0 : {u4_p, u_sb_q[3].tsat};
      flt_out_q <= u_sb_q[3].fault;
    end
  end

  assign m_tdata_o = out_q;
  assign m_tuser_o = flt_out_q;

endmodule

`default_nettype wire

@@ hw/rtl/ptc_checker.sv @@
// Port level checks of the compensation unit and their bind to the top level.
// Depends on pressure_temp_compensation_unit_assert.svh.
`default_nettype none
`include "pressure_temp_compensation_unit_assert.svh"

module ptc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  logic        stalled;
  logic [48:0] beat;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign beat    = {m_axis_tuser, m_axis_tdata};

  // No result is offered while reset is applied.
  `PTC_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !m_axis_tvalid, "result during reset")

  // A stalled result beat holds its content.
  `PTC_ASSERT(a_stall_hold, stalled |=> m_axis_tvalid && $stable(beat), "stalled beat changed")

  // A divide fault forces both results to zero.
  `PTC_ASSERT(a_fault_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "fault with data")

endmodule

bind pressure_temp_compensation_unit ptc_checker u_ptc_checker (.*);

`default_nettype wire
